FILE: rtl/cmm_pkg.sv
// ----------------------------------------------------------------------------
// Cluster membership mutator package
// Sizes, result status codes and register indexes shared by the block and
// its channel interfaces.
// ----------------------------------------------------------------------------
package cmm_pkg;

  // Table dimensions.
  localparam int MAX_NODES    = 1024;
  localparam int MAX_CLUSTERS = 32;

  // Derived widths.
  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CLUS_W = $clog2(MAX_CLUSTERS);
  localparam int SIZE_W = NODE_W + 1;
  localparam int NE_W   = CLUS_W + 1;
  localparam int STAT_W = 3;
  localparam int CIDX_W = 2;
  localparam int CDAT_W = SIZE_W;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_JOINED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_LEFT    = 3'd1;
  localparam logic [STAT_W-1:0] ST_REFUSED = 3'd2;
  localparam logic [STAT_W-1:0] ST_LOADED  = 3'd3;
  localparam logic [STAT_W-1:0] ST_ALREADY = 3'd4;
  localparam logic [STAT_W-1:0] ST_BAD     = 3'd5;

  // Opcodes.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_MUTATE = 1'b1;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_NUM_CLUSTERS    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_NUM_NODES       = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_DOUBLE_MUTATION = 2'd2;

endpackage

FILE: rtl/cmm_in_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one load or mutate item.
// ----------------------------------------------------------------------------
interface cmm_in_if
  import cmm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [NODE_W-1:0] first_node;
  logic [CLUS_W-1:0] first_cluster;
  logic [NODE_W-1:0] second_node;
  logic [CLUS_W-1:0] second_cluster;

  modport source (
    output valid, opcode, first_node, first_cluster, second_node, second_cluster,
    input  ready
  );

  modport sink (
    input  valid, opcode, first_node, first_cluster, second_node, second_cluster,
    output ready
  );
endinterface

FILE: rtl/cmm_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result per handled pair.
// ----------------------------------------------------------------------------
interface cmm_out_if
  import cmm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SIZE_W-1:0] cluster_size;
  logic [NE_W-1:0]   nonempty_clusters;
  logic              last;

  modport source (
    output valid, status, cluster_size, nonempty_clusters, last,
    input  ready
  );

  modport sink (
    input  valid, status, cluster_size, nonempty_clusters, last,
    output ready
  );
endinterface

FILE: rtl/cluster_membership_mutator.sv
// ----------------------------------------------------------------------------
// Cluster membership mutator
// Node-by-cluster membership table in a synchronous memory, with per-cluster
// sizes and a count of non-empty clusters kept in registers.
//
//   Channel  Direction  Contents
//   req      sink       opcode, first/second node and cluster
//   rsp      source     status, cluster_size, nonempty_clusters, last
//   cfg_*    input      write enable, register index, write data
//
// A load item or a single mutate item is read on acceptance and handled in
// S_EXEC1; a double mutate item adds S_EXEC2, the second row read overlapping
// the first write with forwarding. A new item is taken only in S_IDLE. After
// reset a clearing pass zeroes all 1024 table rows; no request is taken
// meanwhile. Each result waits in the output register; a stalled sink holds
// the block in its execute step until the result register frees.
// ----------------------------------------------------------------------------
module cluster_membership_mutator
  import cmm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  cmm_in_if.sink            req,
  cmm_out_if.source         rsp,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_idx,
  input  logic [CDAT_W-1:0] cfg_data
);

  // Sequencer codes.
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC1 = 2'd2;
  localparam logic [1:0] S_EXEC2 = 2'd3;

  logic [1:0]              state;
  logic [1:0]              state_next;
  logic [NODE_W-1:0]       clr_cnt;

  // Configuration registers.
  logic [NE_W-1:0]         num_clusters;
  logic [SIZE_W-1:0]       num_nodes;
  logic                    double_mutation;

  // Item under work.
  logic                    op_load;
  logic                    dbl;
  logic [NODE_W-1:0]       n1;
  logic [CLUS_W-1:0]       c1;
  logic [NODE_W-1:0]       n2;
  logic [CLUS_W-1:0]       c2;

  // Membership memory and its ports.
  logic [MAX_CLUSTERS-1:0] mem [MAX_NODES];
  logic [MAX_CLUSTERS-1:0] rdata;
  logic                    rd_en;
  logic [NODE_W-1:0]       rd_addr;
  logic                    wr_en;
  logic [NODE_W-1:0]       wr_addr;
  logic [MAX_CLUSTERS-1:0] wr_data;

  // Forwarding of the first pair's write to the second pair's read.
  logic                    fwd_wrote;
  logic [MAX_CLUSTERS-1:0] fwd_row;

  // Cluster sizes and non-empty count.
  logic [SIZE_W-1:0]       sizes [MAX_CLUSTERS];
  logic [NE_W-1:0]         nonempty;

  // Execute-step signals.
  logic                    exec;
  logic                    fire;
  logic [NODE_W-1:0]       cur_node;
  logic [CLUS_W-1:0]       cur_clus;
  logic                    cur_load;
  logic [MAX_CLUSTERS-1:0] row;
  logic [MAX_CLUSTERS-1:0] sel_bit;
  logic [MAX_CLUSTERS-1:0] inuse;
  logic                    bad;
  logic                    is_member;
  logic                    others;
  logic [SIZE_W-1:0]       size_cur;
  logic [SIZE_W-1:0]       size_new;
  logic [NE_W-1:0]         ne_new;
  logic [STAT_W-1:0]       status_new;
  logic [MAX_CLUSTERS-1:0] row_new;
  logic                    row_wr;
  logic                    size_wr;
  logic                    last_new;

  assign exec     = (state == S_EXEC1) || (state == S_EXEC2);
  assign fire     = exec && (!rsp.valid || rsp.ready);
  assign req.ready = (state == S_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters    <= NE_W'(MAX_CLUSTERS);
      num_nodes       <= SIZE_W'(MAX_NODES);
      double_mutation <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_NUM_CLUSTERS:    num_clusters    <= cfg_data[NE_W-1:0];
        CFG_NUM_NODES:       num_nodes       <= cfg_data[SIZE_W-1:0];
        CFG_DOUBLE_MUTATION: double_mutation <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture the accepted item.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_load <= (req.opcode == OP_LOAD);
      dbl     <= (req.opcode == OP_MUTATE) && double_mutation;
      n1      <= req.first_node;
      c1      <= req.first_cluster;
      n2      <= req.second_node;
      c2      <= req.second_cluster;
    end
  end

  // Select the pair in work and its row, forwarding the first write.
  always_comb begin
    cur_node = (state == S_EXEC2) ? n2 : n1;
    cur_clus = (state == S_EXEC2) ? c2 : c1;
    cur_load = (state == S_EXEC1) && op_load;
    if ((state == S_EXEC2) && fwd_wrote && (n2 == n1)) begin
      row = fwd_row;
    end else begin
      row = rdata;
    end
  end

  // Decide the outcome for one pair.
  always_comb begin
    sel_bit = '0;
    sel_bit[cur_clus] = 1'b1;
    for (int i = 0; i < MAX_CLUSTERS; i++) begin
      inuse[i] = (NE_W'(i) < num_clusters);
    end
    bad       = ({1'b0, cur_node} >= num_nodes) || ({1'b0, cur_clus} >= num_clusters);
    is_member = row[cur_clus];
    others    = |(row & inuse & ~sel_bit);
    size_cur  = sizes[cur_clus];

    size_new   = size_cur;
    ne_new     = nonempty;
    row_new    = row;
    row_wr     = 1'b0;
    size_wr    = 1'b0;
    status_new = ST_BAD;

    if (bad) begin
      size_new = '0;
    end else if (is_member && cur_load) begin
      status_new = ST_ALREADY;
    end else if (is_member && !others) begin
      status_new = ST_REFUSED;
    end else if (is_member) begin
      // Leave: clear the bit and shrink the cluster.
      status_new = ST_LEFT;
      row_new    = row & ~sel_bit;
      row_wr     = 1'b1;
      size_wr    = 1'b1;
      if (size_cur != '0) begin
        size_new = size_cur - SIZE_W'(1);
        if ((size_new == '0) && (nonempty != '0)) begin
          ne_new = nonempty - NE_W'(1);
        end
      end
    end else begin
      // Join: set the bit and grow the cluster.
      status_new = cur_load ? ST_LOADED : ST_JOINED;
      row_new    = row | sel_bit;
      row_wr     = 1'b1;
      size_wr    = 1'b1;
      if (size_cur < SIZE_W'(MAX_NODES)) begin
        size_new = size_cur + SIZE_W'(1);
      end
      if ((size_new == SIZE_W'(1)) && (nonempty < NE_W'(MAX_CLUSTERS))) begin
        ne_new = nonempty + NE_W'(1);
      end
    end
    last_new = (state == S_EXEC2) || !dbl;
  end

  // Memory port control: clearing pass, then item reads and write-backs.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = n2;
    if (req.valid && req.ready) begin
      rd_en   = 1'b1;
      rd_addr = req.first_node;
    end else if (fire && (state == S_EXEC1) && dbl) begin
      rd_en   = 1'b1;
      rd_addr = n2;
    end
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '0;
    end else begin
      wr_en   = fire && row_wr;
      wr_addr = cur_node;
      wr_data = row_new;
    end
  end

  // Membership memory, one read and one write a cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Keep the first pair's write for a second pair on the same node.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_wrote <= 1'b0;
    end else if (fire && (state == S_EXEC1)) begin
      fwd_wrote <= row_wr;
      fwd_row   <= row_new;
    end
  end

  // Cluster sizes and non-empty count.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        sizes[i] <= '0;
      end
      nonempty <= '0;
    end else if (fire && size_wr) begin
      sizes[cur_clus] <= size_new;
      nonempty        <= ne_new;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == '1) state_next = S_IDLE;
      S_IDLE:  if (req.valid) state_next = S_EXEC1;
      S_EXEC1: if (fire) state_next = dbl ? S_EXEC2 : S_IDLE;
      S_EXEC2: if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + NODE_W'(1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.status            <= status_new;
      rsp.cluster_size      <= size_new;
      rsp.nonempty_clusters <= ne_new;
      rsp.last              <= last_new;
    end
  end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// Cluster membership mutator testbench
// Drives load and mutate items into the block under several register
// settings, predicts every result from a private copy of the membership
// table, the cluster sizes and the non-empty count, and compares each result
// transfer field by field. Both channels idle at random, and one phase holds
// the result channel off long enough to stall the request channel.
// ----------------------------------------------------------------------------
module tb;
  import cmm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SIZE_W-1:0] size;
    logic [NE_W-1:0]   nonempty;
    logic              last;
  } outcome_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_idx;
  logic [CDAT_W-1:0] cfg_data;

  cmm_in_if  req_ch ();
  cmm_out_if rsp_ch ();

  cluster_membership_mutator dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Predicted table, sizes, count and register copies.
  bit [MAX_CLUSTERS-1:0] member_rows [MAX_NODES];
  int unsigned           cluster_count [MAX_CLUSTERS];
  int unsigned           nonempty_total;
  bit [5:0]              nclus_reg;
  bit [10:0]             nnodes_reg;
  bit                    double_reg;

  outcome_t expected_outcomes [$];
  int       fail_count;
  int       quiet_cycles;
  int       hold_request;
  bit       steady_flow;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int active_clusters();
    return (nclus_reg > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(nclus_reg);
  endfunction

  function automatic int active_nodes();
    return (nnodes_reg > MAX_NODES) ? MAX_NODES : int'(nnodes_reg);
  endfunction

  function automatic void push_outcome(logic [STAT_W-1:0] status, int unsigned size);
    outcome_t o;
    o.status   = status;
    o.size     = size[SIZE_W-1:0];
    o.nonempty = nonempty_total[NE_W-1:0];
    o.last     = 1'b0;
    expected_outcomes.insert(expected_outcomes.size(), o);
  endfunction

  function automatic void join_cluster(int node, int clus);
    member_rows[node][clus] = 1'b1;
    if (cluster_count[clus] < MAX_NODES) cluster_count[clus]++;
    if (cluster_count[clus] == 1 && nonempty_total < MAX_CLUSTERS) nonempty_total++;
  endfunction

  // Applies one (node, cluster) pair to the predicted state and queues its result.
  function automatic void update_membership(bit is_load, int node, int clus);
    int                    ncl;
    bit [MAX_CLUSTERS-1:0] in_use;
    bit [MAX_CLUSTERS-1:0] others;
    ncl = active_clusters();
    if (node >= active_nodes() || clus >= ncl) begin
      push_outcome(ST_BAD, 0);
    end else if (is_load) begin
      if (member_rows[node][clus]) begin
        push_outcome(ST_ALREADY, cluster_count[clus]);
      end else begin
        join_cluster(node, clus);
        push_outcome(ST_LOADED, cluster_count[clus]);
      end
    end else if (member_rows[node][clus]) begin
      // Only memberships in clusters still in use count as other memberships.
      for (int i = 0; i < MAX_CLUSTERS; i++) in_use[i] = (i < ncl);
      others = member_rows[node] & in_use;
      others[clus] = 1'b0;
      if (others == '0) begin
        push_outcome(ST_REFUSED, cluster_count[clus]);
      end else begin
        member_rows[node][clus] = 1'b0;
        if (cluster_count[clus] > 0) begin
          cluster_count[clus]--;
          if (cluster_count[clus] == 0 && nonempty_total > 0) nonempty_total--;
        end
        push_outcome(ST_LEFT, cluster_count[clus]);
      end
    end else begin
      join_cluster(node, clus);
      push_outcome(ST_JOINED, cluster_count[clus]);
    end
  endfunction

  // Works out every result of one accepted item and marks the final one.
  function automatic void predict_outcomes(logic op, int n1, int c1, int n2, int c2);
    update_membership(op == OP_LOAD, n1, c1);
    if (op == OP_MUTATE && double_reg) update_membership(1'b0, n2, c2);
    expected_outcomes[expected_outcomes.size() - 1].last = 1'b1;
  endfunction

  // Offers one item after a random gap and waits for its transfer.
  task automatic send_item(input logic op, input int n1, c1, n2 = 0, c2 = 0);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.opcode         <= op;
    req_ch.first_node     <= n1[NODE_W-1:0];
    req_ch.first_cluster  <= c1[CLUS_W-1:0];
    req_ch.second_node    <= n2[NODE_W-1:0];
    req_ch.second_cluster <= c2[CLUS_W-1:0];
    do @(posedge clk); while (!req_ch.ready);
    predict_outcomes(op, n1 % MAX_NODES, c1 % MAX_CLUSTERS, n2 % MAX_NODES,
                     c2 % MAX_CLUSTERS);
  endtask

  // Stops offering and waits until every predicted result has been seen.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers while the block is idle.
  task automatic program_block(input int nclus, input int nnodes, input bit dbl);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_NUM_CLUSTERS;
    cfg_data <= nclus[CDAT_W-1:0];
    @(posedge clk);
    cfg_idx  <= CFG_NUM_NODES;
    cfg_data <= nnodes[CDAT_W-1:0];
    @(posedge clk);
    cfg_idx  <= CFG_DOUBLE_MUTATION;
    cfg_data <= CDAT_W'(dbl);
    @(posedge clk);
    cfg_we   <= 1'b0;
    nclus_reg  = nclus[5:0];
    nnodes_reg = nnodes[10:0];
    double_reg = dbl;
  endtask

  // Loads, repeated loads, toggles and the refusal of a node's only membership.
  task automatic test_directed_basics();
    program_block(32, 1024, 1'b0);
    send_item(OP_LOAD, 0, 0);
    send_item(OP_LOAD, 0, 0);
    send_item(OP_LOAD, 1023, 31);
    send_item(OP_MUTATE, 1023, 31);
    send_item(OP_MUTATE, 0, 5);
    send_item(OP_MUTATE, 0, 0);
    send_item(OP_MUTATE, 0, 0);
    send_item(OP_MUTATE, 341, 10, 1023, 31);
  endtask

  // Bad indexes, double mode, zero and oversized registers, lowered cluster count.
  task automatic test_directed_ranges();
    program_block(4, 8, 1'b0);
    send_item(OP_LOAD, 8, 0);
    send_item(OP_LOAD, 7, 4);
    send_item(OP_LOAD, 7, 3);
    program_block(4, 8, 1'b1);
    send_item(OP_MUTATE, 7, 2, 7, 2);
    send_item(OP_MUTATE, 9, 0, 7, 1);
    send_item(OP_MUTATE, 7, 1, 5, 30);
    send_item(OP_LOAD, 6, 0, 6, 1);
    // Node 0 holds clusters 0 and 5; cluster 5 is now beyond the count in use.
    program_block(4, 1024, 1'b1);
    send_item(OP_MUTATE, 0, 0, 0, 0);
    program_block(0, 1024, 1'b1);
    send_item(OP_MUTATE, 0, 0, 1, 1);
    program_block(32, 0, 1'b0);
    send_item(OP_LOAD, 0, 0);
    program_block(63, 2047, 1'b1);
    send_item(OP_MUTATE, 1023, 31, 1023, 30);
    send_item(OP_LOAD, 1023, 31);
    send_item(OP_MUTATE, 682, 21, 682, 21);
  endtask

  // One random phase: mostly hot nodes so that toggles meet earlier loads.
  task automatic run_random(input int nclus, input int nnodes, input bit dbl,
                            input int count);
    int   pool [8];
    int   eff_n;
    int   eff_c;
    int   node [2];
    int   clus [2];
    int   r;
    logic op;
    program_block(nclus, nnodes, dbl);
    eff_n = active_nodes();
    eff_c = active_clusters();
    foreach (pool[i]) pool[i] = (eff_n > 0) ? $urandom_range(0, eff_n - 1) : 0;
    pool[0] = (eff_n > 0) ? eff_n - 1 : 0;
    for (int k = 0; k < count; k++) begin
      steady_flow = (k < count / 4);
      for (int j = 0; j < 2; j++) begin
        r = $urandom_range(0, 19);
        if (r < 15) node[j] = pool[$urandom_range(0, 7)];
        else if (r < 18) node[j] = $urandom_range(0, MAX_NODES - 1);
        else node[j] = eff_n % MAX_NODES;
        r = $urandom_range(0, 19);
        if (r < 17 && eff_c > 0) clus[j] = $urandom_range(0, eff_c - 1);
        else clus[j] = $urandom_range(0, MAX_CLUSTERS - 1);
      end
      op = ($urandom_range(0, 99) < 35) ? OP_LOAD : OP_MUTATE;
      send_item(op, node[0], clus[0], node[1], clus[1]);
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_random_phases();
    run_random(32, 1024, 1'b1, 90);
    run_random(5, 12, 1'b0, 90);
    run_random(1, 1024, 1'b1, 50);
    run_random(20, 1, 1'b1, 40);
    run_random(8, 64, 1'b1, 80);
  endtask

  // The result side stops for a long stretch while items keep coming.
  task automatic test_backpressure();
    program_block(32, 300, 1'b1);
    hold_request = 250;
    steady_flow  = 1'b1;
    for (int k = 0; k < 40; k++) begin
      send_item(OP_MUTATE, $urandom_range(0, 15), $urandom_range(0, 31),
                $urandom_range(0, 15), $urandom_range(0, 31));
    end
    steady_flow = 1'b0;
  endtask

  // Result side: random stalls per transfer, or one long hold when requested.
  initial begin
    int wait_n;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request > 0) begin
        wait_n = hold_request;
        hold_request = 0;
      end else begin
        wait_n = steady_flow ? 0 : $urandom_range(0, 8);
      end
      if (wait_n > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid && hold_request == 0);
    end
  end

  task automatic report_mismatch(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    fail_count++;
  endtask

  // Compares each result transfer with the oldest prediction.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: result transfer with no prediction waiting, status %0d",
                 $time, rsp_ch.status);
        fail_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", 16'(want.status), 16'(rsp_ch.status));
        if (rsp_ch.cluster_size !== want.size)
          report_mismatch("cluster_size", 16'(want.size), 16'(rsp_ch.cluster_size));
        if (rsp_ch.nonempty_clusters !== want.nonempty)
          report_mismatch("nonempty_clusters", 16'(want.nonempty),
                          16'(rsp_ch.nonempty_clusters));
        if (rsp_ch.last !== want.last)
          report_mismatch("last", 16'(want.last), 16'(rsp_ch.last));
      end
    end
  end

  // Ends the run when no transfer or register write happens for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, expected_outcomes.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_idx               <= CFG_NUM_CLUSTERS;
    cfg_data              <= '0;
    req_ch.valid          <= 1'b0;
    req_ch.opcode         <= OP_LOAD;
    req_ch.first_node     <= '0;
    req_ch.first_cluster  <= '0;
    req_ch.second_node    <= '0;
    req_ch.second_cluster <= '0;
    fail_count     = 0;
    quiet_cycles   = 0;
    hold_request   = 0;
    steady_flow    = 1'b0;
    nonempty_total = 0;
    nclus_reg      = 6'd32;
    nnodes_reg     = 11'd1024;
    double_reg     = 1'b0;
    foreach (cluster_count[i]) cluster_count[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed_basics();
    test_directed_ranges();
    test_random_phases();
    test_backpressure();
    drain_results();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
